### rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/lz78_pkg.sv
`timescale 1ns / 1ps

package lz78_pkg;

    localparam int BYTE_W     = 8;
    localparam int PREFIX_W   = 10;
    localparam logic [BYTE_W-1:0] END_SYMBOL = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } t_req;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_index;
        logic [BYTE_W-1:0]   symbol;
        logic                end_marker;
    } t_res;

endpackage

### rtl/lz78_stream_if.sv
`timescale 1ns / 1ps

interface lz78_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lz78_fifo.sv
`timescale 1ns / 1ps

module lz78_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz78_stream_if.sink   i_push,
    lz78_stream_if.source o_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign i_push.ready  = (r_count != CW'(DEPTH));
    assign o_pop.valid   = (r_count != '0);
    assign o_pop.payload = r_mem[r_rd_ptr];

    assign w_push = i_push.valid && i_push.ready;
    assign w_pop  = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/lz78_engine.sv
`timescale 1ns / 1ps

module lz78_engine import lz78_pkg::*; #(
    parameter int DICT_ENTRIES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz78_stream_if.sink   i_req,
    lz78_stream_if.source o_res
);

    localparam int PW    = (DICT_ENTRIES > 2) ? $clog2(DICT_ENTRIES) : 1;
    localparam int AW    = PW + BYTE_W;
    localparam int DEPTH = DICT_ENTRIES * (1 << BYTE_W);
    localparam int XW    = (PW > PREFIX_W) ? PW : PREFIX_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE
    } t_state;

    logic [PW-1:0]     r_mem [DEPTH];

    t_state            r_state;
    logic [AW-1:0]     r_clr;
    logic [PW-1:0]     r_cur;
    logic [PW-1:0]     n_cur;
    logic [PW:0]       r_next;
    logic [PW:0]       n_next;
    logic [PW-1:0]     r_rdata;
    logic [BYTE_W-1:0] r_byte;
    logic              r_fin;

    logic              w_accept;
    logic [AW-1:0]     w_rd_addr;
    logic              w_hit;
    logic              w_room;
    logic              w_add;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    logic [PW-1:0]     w_wd;
    logic [PW-1:0]     w_phrase;
    logic [XW-1:0]     w_phrase_ext;

    assign i_req.ready = (r_state == ST_IDLE) && o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_rd_addr   = {r_cur, i_req.payload.data_byte};

    assign w_hit  = (r_rdata != '0);
    assign w_room = (r_next < (PW + 1)'(DICT_ENTRIES));
    assign w_add  = (r_state == ST_DECIDE) && !w_hit && w_room;

    assign w_we = (r_state == ST_CLEAR) || w_add;
    assign w_wa = (r_state == ST_CLEAR) ? r_clr : {r_cur, r_byte};
    assign w_wd = (r_state == ST_CLEAR) ? '0 : r_next[PW-1:0];

    assign w_phrase     = w_hit ? r_rdata : r_cur;
    assign w_phrase_ext = XW'(w_phrase);

    assign o_res.valid                = (r_state == ST_DECIDE) && !(w_hit && !r_fin);
    assign o_res.payload.prefix_index = w_phrase_ext[PREFIX_W-1:0];
    assign o_res.payload.symbol       = w_hit ? END_SYMBOL : r_byte;
    assign o_res.payload.end_marker   = w_hit;

    always_comb begin
        n_cur  = r_cur;
        n_next = r_next;
        if (r_state == ST_DECIDE) begin
            n_cur = (w_hit && !r_fin) ? r_rdata : '0;
            if (w_add) begin
                n_next = r_next + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_accept) begin
            r_rdata <= r_mem[w_rd_addr];
            r_byte  <= i_req.payload.data_byte;
            r_fin   <= i_req.payload.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cur   <= '0;
            r_next  <= (PW + 1)'(1);
        end else begin
            r_cur  <= n_cur;
            r_next <= n_next;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/lz78_encoder.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// LZ78 encoder, one byte per request. A two-entry input queue takes bytes while the
// lookup engine works, and a two-entry output queue holds (prefix_index, symbol,
// end_marker) results while the consumer stalls. The engine works on each byte in steps:
// a read of the child table at {current phrase, byte}, whose registered data forms
// the next lookup key, then a step to decide, emit and write a new entry. It takes no
// new byte until that step ends or while the output queue is full; a byte that extends
// the match emits nothing. After reset the engine clears the child table one entry a
// cycle, all DICT_ENTRIES * 256 entries (262144 at the default); the input queue fills
// with two bytes and then stalls until the pass ends. Phrase numbers run from 1 to
// DICT_ENTRIES - 1; once they run out the dictionary stops growing. A final byte that
// completes a known phrase emits that phrase with symbol 0xFF and end_marker set.
module lz78_encoder import lz78_pkg::*; #(
    parameter int DICT_ENTRIES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz78_stream_if.sink   i_req,
    lz78_stream_if.source o_res
);

    lz78_stream_if #(.T(t_req)) w_req_q ();
    lz78_stream_if #(.T(t_res)) w_res_q ();

    lz78_fifo #(
        .T     (t_req),
        .DEPTH (2)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_req),
        .o_pop   (w_req_q)
    );

    lz78_engine #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_q),
        .o_res   (w_res_q)
    );

    lz78_fifo #(
        .T     (t_res),
        .DEPTH (2)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_q),
        .o_pop   (o_res)
    );

    `LZ_ASSERT_SAME(a_res_no_overflow, i_clk, i_rst_n, w_res_q.valid, w_res_q.ready)
    `LZ_ASSERT_SAME(a_take_or_emit, i_clk, i_rst_n, w_req_q.valid && w_req_q.ready, !w_res_q.valid)
    `LZ_ASSERT_NEXT(a_two_cycle_step, i_clk, i_rst_n, w_req_q.valid && w_req_q.ready, !w_req_q.ready)
    `LZ_ASSERT_SAME(a_end_symbol, i_clk, i_rst_n, o_res.valid && o_res.payload.end_marker, o_res.payload.symbol == END_SYMBOL)

endmodule
